// ===== rtl/core/dda_pkg.sv =====
// Shared types, codes and constants for the differential drive mixer with auto stop.
package dda_pkg;

  // Widths fixed by the item fields
  localparam int DRIVE_W    = 9;
  localparam int LIMIT_W    = 8;
  localparam int TIME_W     = 32;
  localparam int DIST_W     = 24;
  localparam int SUM_IN_W   = DRIVE_W + 2;   // velocity +- turn
  localparam int MAG_W      = DRIVE_W + 1;   // magnitude up to 512
  localparam int PROD_W     = MAG_W + LIMIT_W;
  localparam int QUOT_W     = LIMIT_W;       // scaled value never exceeds the limit
  localparam int DIV_STEPS  = QUOT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LIMIT_W;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 24;

  localparam int COUNT_BITS_DEF = 24;
  localparam logic [LIMIT_W-1:0] MAX_DRIVE_RST = 8'd255;

  // Command codes carried in tuser
  typedef enum logic [2:0] {
    FN_DRIVE      = 3'd0,
    FN_DRIVE_FOR  = 3'd1,
    FN_DRIVE_DIST = 3'd2,
    FN_ROTATE     = 3'd3,
    FN_STOP       = 3'd4,
    FN_TICK       = 3'd5,
    FN_RPULSE     = 3'd6,
    FN_LPULSE     = 3'd7
  } func_t;

  // Automatic drive state as reported
  typedef enum logic [1:0] {
    RS_IDLE  = 2'd0,
    RS_TIMED = 2'd1,
    RS_DIST  = 2'd2
  } run_state_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_DRIVE = 1'd0,
    CFG_AUTO_MODE = 1'd1
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_LOAD,
    ST_OUT
  } ctrl_state_t;

  // One input item
  typedef struct packed {
    func_t                      func;
    logic signed [DRIVE_W-1:0]  velocity;
    logic signed [DRIVE_W-1:0]  turn;
    logic [TIME_W-1:0]          duration_ms;
    logic [DIST_W-1:0]          distance_ticks;
    logic                       angle_positive;
  } in_item_t;

  // One result item, last field in the low bits
  typedef struct packed {
    logic                       moving;
    logic                       auto_done;
    run_state_t                 run_state;
    logic signed [DRIVE_W-1:0]  left_drive;
    logic signed [DRIVE_W-1:0]  right_drive;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic mul;
    logic div_step;
    logic lvl_load;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
  } dp_status_t;

endpackage

// ===== rtl/core/dda_ctrl.sv =====
// Sequencer for the drive mixer: handshakes, command steps and divider step count.
module dda_ctrl
  import dda_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t           state_r, state_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;
  logic                  div_last;

  assign out_free = !out_valid_r || out_tready;
  assign div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = status.need_div ? ST_MUL : ST_OUT;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (div_last) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_EXEC: cmd.exec     = 1'b1;
      ST_MUL:  cmd.mul      = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_LOAD: cmd.lvl_load = 1'b1;
      ST_OUT:  cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  // Divider step counter and result valid
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.mul) begin
      cnt_nxt = '0;
    end else if (cmd.div_step) begin
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/dda_dp.sv =====
// Datapath for the drive mixer: drive state, counters, scaling multiply and two-lane divider.
module dda_dp
  import dda_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output result_t               result
);

  localparam int SUM_W = (COUNT_BITS + 1 > DIST_W + 1) ? COUNT_BITS + 1 : DIST_W + 1;

  // Latched item
  in_item_t                  item_r;

  // Configuration
  logic [LIMIT_W-1:0]        max_drive_r, max_drive_nxt;
  logic                      auto_r, auto_nxt;

  // Drive state
  logic signed [DRIVE_W-1:0] rlev_r, rlev_nxt, llev_r, llev_nxt;
  run_state_t                dstate_r, dstate_nxt;
  logic [TIME_W-1:0]         elapsed_r, elapsed_nxt, timeout_r, timeout_nxt;
  logic [DIST_W-1:0]         target_r, target_nxt;
  logic [COUNT_BITS-1:0]     rcnt_r, rcnt_nxt, lcnt_r, lcnt_nxt;
  logic                      done_r, done_nxt;

  // Scaling operands and divider lanes
  logic [MAG_W-1:0]          ar_r, al_r, m_r;
  logic                      rneg_r, lneg_r;
  logic [MAG_W-1:0]          rrem_r, lrem_r;
  logic [QUOT_W-1:0]         rlow_r, llow_r, rq_r, lq_r;
  result_t                   result_r;

  // Combinational temporaries
  logic                      driving, do_mix, do_stop, scale;
  logic signed [DRIVE_W-1:0] mv, mt;
  logic signed [SUM_IN_W-1:0] rsum, lsum;
  logic [MAG_W-1:0]          rabs, labs, mag;
  logic [TIME_W-1:0]         e_inc;
  logic [SUM_W-1:0]          cnt_sum, tgt2;
  logic [PROD_W-1:0]         rprod, lprod;
  logic [MAG_W:0]            rtry, ltry;
  logic                      rge, lge;

  assign driving = (rlev_r != '0) || (llev_r != '0);
  assign e_inc   = (elapsed_r == '1) ? elapsed_r : elapsed_r + TIME_W'(1);
  assign cnt_sum = SUM_W'(rcnt_r) + SUM_W'(lcnt_r);
  assign tgt2    = SUM_W'({target_r, 1'b0});

  // Mixer operands, magnitudes and the scale decision
  always_comb begin
    do_mix  = 1'b0;
    mv      = item_r.velocity;
    mt      = item_r.turn;
    unique case (item_r.func)
      FN_DRIVE:      do_mix = 1'b1;
      FN_DRIVE_FOR:  do_mix = (item_r.duration_ms != '0);
      FN_DRIVE_DIST: begin
        do_mix = (item_r.distance_ticks != '0);
        mt     = '0;
      end
      FN_ROTATE: begin
        do_mix = item_r.angle_positive;
        mv     = '0;
      end
      default:       do_mix = 1'b0;
    endcase
    rsum  = {{2{mv[DRIVE_W-1]}}, mv} + {{2{mt[DRIVE_W-1]}}, mt};
    lsum  = {{2{mv[DRIVE_W-1]}}, mv} - {{2{mt[DRIVE_W-1]}}, mt};
    rabs  = rsum[SUM_IN_W-1] ? MAG_W'(SUM_IN_W'(0) - rsum) : rsum[MAG_W-1:0];
    labs  = lsum[SUM_IN_W-1] ? MAG_W'(SUM_IN_W'(0) - lsum) : lsum[MAG_W-1:0];
    mag   = (rabs > labs) ? rabs : labs;
    scale = do_mix && (mv != '0 || mt != '0) && (mag > MAG_W'(max_drive_r));
  end

  assign status.need_div = cmd.exec && scale;

  // Command execution and configuration writes
  always_comb begin
    max_drive_nxt = max_drive_r;
    auto_nxt      = auto_r;
    rlev_nxt      = rlev_r;
    llev_nxt      = llev_r;
    dstate_nxt    = dstate_r;
    elapsed_nxt   = elapsed_r;
    timeout_nxt   = timeout_r;
    target_nxt    = target_r;
    rcnt_nxt      = rcnt_r;
    lcnt_nxt      = lcnt_r;
    done_nxt      = done_r;
    do_stop       = 1'b0;

    if (cmd.exec) begin
      done_nxt = 1'b0;
      unique case (item_r.func)
        FN_DRIVE_FOR: begin
          if (item_r.duration_ms != '0) begin
            dstate_nxt  = RS_TIMED;
            timeout_nxt = item_r.duration_ms;
            elapsed_nxt = '0;
          end
        end
        FN_DRIVE_DIST: begin
          if (item_r.distance_ticks != '0) begin
            dstate_nxt = RS_DIST;
            rcnt_nxt   = '0;
            lcnt_nxt   = '0;
            target_nxt = item_r.distance_ticks;
          end
        end
        FN_STOP: do_stop = 1'b1;
        FN_TICK: begin
          if (auto_r && driving) begin
            case (dstate_r)
              RS_TIMED: begin
                elapsed_nxt = e_inc;
                if (e_inc >= timeout_r) begin
                  do_stop  = 1'b1;
                  done_nxt = 1'b1;
                end
              end
              RS_DIST: begin
                if (cnt_sum >= tgt2) begin
                  do_stop  = 1'b1;
                  done_nxt = 1'b1;
                end
              end
              default: do_stop = 1'b0;
            endcase
          end
        end
        FN_RPULSE: if (rcnt_r != '1) rcnt_nxt = rcnt_r + COUNT_BITS'(1);
        FN_LPULSE: if (lcnt_r != '1) lcnt_nxt = lcnt_r + COUNT_BITS'(1);
        default:   do_stop = 1'b0;
      endcase

      // A zero command acts as stop
      if (do_mix && mv == '0 && mt == '0) begin
        do_stop = 1'b1;
      end

      if (do_stop && driving) begin
        rlev_nxt = '0;
        llev_nxt = '0;
        rcnt_nxt = '0;
        lcnt_nxt = '0;
        if (auto_r) begin
          elapsed_nxt = '0;
          timeout_nxt = '0;
          target_nxt  = '0;
          dstate_nxt  = RS_IDLE;
        end
      end else if (do_mix && !scale && (mv != '0 || mt != '0)) begin
        // Within the limit: levels taken directly
        rlev_nxt = rsum[DRIVE_W-1:0];
        llev_nxt = lsum[DRIVE_W-1:0];
      end
    end

    // Scaled levels from the divider, sign restored
    if (cmd.lvl_load) begin
      rlev_nxt = rneg_r ? DRIVE_W'(DRIVE_W'(0) - {1'b0, rq_r}) : {1'b0, rq_r};
      llev_nxt = lneg_r ? DRIVE_W'(DRIVE_W'(0) - {1'b0, lq_r}) : {1'b0, lq_r};
    end

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_DRIVE: max_drive_nxt = cfg_data;
        CFG_AUTO_MODE: begin
          auto_nxt = cfg_data[0];
          if (!cfg_data[0]) dstate_nxt = RS_IDLE;
        end
        default:       auto_nxt = auto_r;
      endcase
    end
  end

  // Control and drive state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_drive_r <= MAX_DRIVE_RST;
      auto_r      <= 1'b0;
      rlev_r      <= '0;
      llev_r      <= '0;
      dstate_r    <= RS_IDLE;
      elapsed_r   <= '0;
      timeout_r   <= '0;
      target_r    <= '0;
      rcnt_r      <= '0;
      lcnt_r      <= '0;
      done_r      <= 1'b0;
    end else begin
      max_drive_r <= max_drive_nxt;
      auto_r      <= auto_nxt;
      rlev_r      <= rlev_nxt;
      llev_r      <= llev_nxt;
      dstate_r    <= dstate_nxt;
      elapsed_r   <= elapsed_nxt;
      timeout_r   <= timeout_nxt;
      target_r    <= target_nxt;
      rcnt_r      <= rcnt_nxt;
      lcnt_r      <= lcnt_nxt;
      done_r      <= done_nxt;
    end
  end

  // Scaling: magnitude times limit, then restoring division by the larger magnitude
  assign rprod = PROD_W'(ar_r) * PROD_W'(max_drive_r);
  assign lprod = PROD_W'(al_r) * PROD_W'(max_drive_r);
  assign rtry  = {rrem_r, rlow_r[QUOT_W-1]};
  assign ltry  = {lrem_r, llow_r[QUOT_W-1]};
  assign rge   = (rtry >= {1'b0, m_r});
  assign lge   = (ltry >= {1'b0, m_r});

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.exec) begin
      ar_r   <= rabs;
      al_r   <= labs;
      m_r    <= mag;
      rneg_r <= rsum[SUM_IN_W-1];
      lneg_r <= lsum[SUM_IN_W-1];
    end
    if (cmd.mul) begin
      // Quotient fits in QUOT_W bits, so the top part starts below the divisor
      rrem_r <= {1'b0, rprod[PROD_W-2:QUOT_W]};
      lrem_r <= {1'b0, lprod[PROD_W-2:QUOT_W]};
      rlow_r <= rprod[QUOT_W-1:0];
      llow_r <= lprod[QUOT_W-1:0];
      rq_r   <= '0;
      lq_r   <= '0;
    end else if (cmd.div_step) begin
      rrem_r <= rge ? MAG_W'(rtry - {1'b0, m_r}) : rtry[MAG_W-1:0];
      lrem_r <= lge ? MAG_W'(ltry - {1'b0, m_r}) : ltry[MAG_W-1:0];
      rlow_r <= {rlow_r[QUOT_W-2:0], 1'b0};
      llow_r <= {llow_r[QUOT_W-2:0], 1'b0};
      rq_r   <= {rq_r[QUOT_W-2:0], rge};
      lq_r   <= {lq_r[QUOT_W-2:0], lge};
    end
    if (cmd.out_load) begin
      result_r.right_drive <= rlev_r;
      result_r.left_drive  <= llev_r;
      result_r.run_state   <= dstate_r;
      result_r.auto_done   <= done_r;
      result_r.moving      <= driving;
    end
  end

  assign result = result_r;

endmodule

// ===== rtl/core/differential_drive_autostop.sv =====
// Differential drive mixer with timed and distance auto stop.
// Each item runs EXEC then OUT, or EXEC, MUL, DIV, LOAD, OUT when the mix must be scaled.
// Items are taken one at a time; a scaled item also runs the 8-step divider.
// The result sits in an output register; the next item is taken once it has been loaded.
// Synchronous active-low reset: levels, counters and timer cleared, max_drive 255, manual mode.
module differential_drive_autostop
  import dda_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // velocity[8:0], turn[17:9], duration_ms[49:18], distance_ticks[73:50],
  // angle_positive[74], zero pad above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func[2:0]
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // right_drive[8:0], left_drive[17:9], run_state[19:18], auto_done[20],
  // moving[21], zero pad above
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  in_item_t   in_item;
  result_t    result;

  // Unpack the input transfer
  always_comb begin
    in_item.func           = func_t'(in_tuser);
    in_item.velocity       = in_tdata[8:0];
    in_item.turn           = in_tdata[17:9];
    in_item.duration_ms    = in_tdata[49:18];
    in_item.distance_ticks = in_tdata[73:50];
    in_item.angle_positive = in_tdata[74];
  end

  assign cfg_ready = 1'b1;
  assign out_tdata = {(OUT_DATA_W - $bits(result_t))'(0), result};

  dda_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  dda_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_item    (in_item),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_idx_t'(cfg_index)),
    .cfg_data   (cfg_data),
    .result     (result)
  );

endmodule

// ===== tb/sv/dda_checker.sv =====
// Drive mixer checker: predicts every result from accepted commands and compares it.
module dda_checker
  import dda_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // velocity[8:0], turn[17:9], duration_ms[49:18], distance_ticks[73:50],
  // angle_positive[74], zero pad above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func[2:0]
  input  logic [2:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // right_drive[8:0], left_drive[17:9], run_state[19:18], auto_done[20],
  // moving[21], zero pad above
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

  // Shadow of the configuration and of the drive state
  logic [LIMIT_W-1:0] limit_q;
  logic               auto_q;
  int                 right_lvl;
  int                 left_lvl;
  run_state_t         run_q;
  logic [TIME_W-1:0]  elapsed_q;
  logic [TIME_W-1:0]  timeout_q;
  logic [DIST_W-1:0]  target_q;
  longint unsigned    right_cnt;
  longint unsigned    left_cnt;

  result_t            drive_results_q[$];
  int                 mismatches;

  function automatic logic is_driving();
    return (right_lvl != 0) || (left_lvl != 0);
  endfunction

  // Stop: nothing happens when both levels are already zero
  function automatic void halt_drive();
    if (!is_driving())
      return;
    right_lvl = 0;
    left_lvl  = 0;
    right_cnt = 0;
    left_cnt  = 0;
    if (auto_q) begin
      elapsed_q = '0;
      timeout_q = '0;
      target_q  = '0;
      run_q     = RS_IDLE;
    end
  endfunction

  function automatic int clamp_level(int v, int lim);
    if (v > lim)
      return lim;
    if (v < -lim)
      return -lim;
    return v;
  endfunction

  // Mix velocity and turn, scale down by limit/magnitude, then clamp; a zero command stops
  function automatic void mix_levels(int vel, int trn);
    int r;
    int l;
    int m;
    int lim;
    lim = int'(limit_q);
    if (vel == 0 && trn == 0) begin
      halt_drive();
      return;
    end
    r = vel + trn;
    l = vel - trn;
    m = ((r < 0) ? -r : r);
    if (((l < 0) ? -l : l) > m)
      m = (l < 0) ? -l : l;
    if (m > lim) begin
      r = (r * lim) / m;
      l = (l * lim) / m;
    end
    right_lvl = clamp_level(r, lim);
    left_lvl  = clamp_level(l, lim);
  endfunction

  // Millisecond tick: only armed in auto mode with the motors running
  function automatic logic tick_autostop();
    if (!auto_q || !is_driving())
      return 1'b0;
    if (run_q == RS_TIMED) begin
      if (elapsed_q != '1)
        elapsed_q = elapsed_q + 1'b1;
      if (elapsed_q >= timeout_q) begin
        halt_drive();
        return 1'b1;
      end
    end else if (run_q == RS_DIST) begin
      if (right_cnt + left_cnt >= 64'(target_q) * 64'd2) begin
        halt_drive();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic result_t predict_drive(logic [IN_DATA_W-1:0] data, logic [2:0] fn);
    int                vel;
    int                trn;
    logic [TIME_W-1:0] dur;
    logic [DIST_W-1:0] ticks;
    logic              ang;
    logic              done;
    result_t           res;
    vel   = int'($signed(data[8:0]));
    trn   = int'($signed(data[17:9]));
    dur   = data[49:18];
    ticks = data[73:50];
    ang   = data[74];
    done  = 1'b0;
    case (func_t'(fn))
      FN_DRIVE: begin
        mix_levels(vel, trn);
      end
      FN_DRIVE_FOR: begin
        if (dur != '0) begin
          run_q     = RS_TIMED;
          timeout_q = dur;
          elapsed_q = '0;
          mix_levels(vel, trn);
        end
      end
      FN_DRIVE_DIST: begin
        if (ticks != '0) begin
          run_q     = RS_DIST;
          right_cnt = 0;
          left_cnt  = 0;
          target_q  = ticks;
          mix_levels(vel, 0);
        end
      end
      FN_ROTATE: begin
        if (ang)
          mix_levels(0, trn);
      end
      FN_STOP: begin
        halt_drive();
      end
      FN_TICK: begin
        done = tick_autostop();
      end
      FN_RPULSE: begin
        if (right_cnt < COUNT_MAX)
          right_cnt++;
      end
      default: begin
        if (left_cnt < COUNT_MAX)
          left_cnt++;
      end
    endcase
    res.right_drive = right_lvl[DRIVE_W-1:0];
    res.left_drive  = left_lvl[DRIVE_W-1:0];
    res.run_state   = run_q;
    res.auto_done   = done;
    res.moving      = is_driving();
    return res;
  endfunction

  // Watch the three channels: register writes, results, then new commands
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      limit_q    = MAX_DRIVE_RST;
      auto_q     = 1'b0;
      right_lvl  = 0;
      left_lvl   = 0;
      run_q      = RS_IDLE;
      elapsed_q  = '0;
      timeout_q  = '0;
      target_q   = '0;
      right_cnt  = 0;
      left_cnt   = 0;
      mismatches = 0;
      drive_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_DRIVE) begin
          limit_q = cfg_data;
        end else begin
          auto_q = cfg_data[0];
          if (!auto_q)
            run_q = RS_IDLE;
        end
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (drive_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: result transfer with nothing outstanding", $time);
        end else begin
          want = drive_results_q.pop_front();
          if (got.right_drive !== want.right_drive || got.left_drive !== want.left_drive ||
              got.run_state !== want.run_state || got.auto_done !== want.auto_done ||
              got.moving !== want.moving) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: exp r=%0d l=%0d st=%0d done=%b mov=%b,",
                       $time, want.right_drive, want.left_drive, want.run_state,
                       want.auto_done, want.moving,
                       " got r=%0d l=%0d st=%0d done=%b mov=%b",
                       got.right_drive, got.left_drive,
                       got.run_state, got.auto_done, got.moving);
          end
        end
      end
      if (in_tvalid && in_tready)
        drive_results_q.push_back(predict_drive(in_tdata, in_tuser));
    end
    fail_count <= mismatches;
    pending    <= drive_results_q.size();
  end

endmodule

// ===== tb/sv/tb_differential_drive_autostop.sv =====
// Testbench top for the drive mixer: stimulus, output back-pressure and the verdict.
module tb_differential_drive_autostop;
  import dda_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 600;
  localparam int PHASES       = 6;
  localparam int LONG_HOLD    = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [2:0]            in_tuser = FN_DRIVE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MAX_DRIVE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   sent_count = 0;
  int   settings_count = 0;
  int   long_holds = 0;
  int   hold_reqs = 0;
  logic no_idle = 1'b0;

  always #4 clk = ~clk;

  differential_drive_autostop dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  dda_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stall before each transfer, or a long hold on request
  initial begin : result_sink
    int stall;
    int holds_seen;
    holds_seen = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_reqs != holds_seen) begin
        holds_seen = hold_reqs;
        stall      = LONG_HOLD;
        long_holds++;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // One command transfer after a random gap
  task automatic send_cmd(func_t fn, int vel, int trn, logic [TIME_W-1:0] dur,
                          logic [DIST_W-1:0] ticks, logic ang);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {5'b0, ang, ticks, dur, trn[DRIVE_W-1:0], vel[DRIVE_W-1:0]};
    in_tuser  <= fn;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  // Stop offering and wait until every result is back, plus the pipeline depth
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write both registers back to back; only called with the block drained
  task automatic program_regs(logic [LIMIT_W-1:0] limit, logic auto_on);
    cfg_index <= CFG_MAX_DRIVE;
    cfg_data  <= limit;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_AUTO_MODE;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, auto_on};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  function automatic int rand_speed();
    if ($urandom_range(0, 8) == 0)
      return 0;
    return int'($urandom_range(0, 510)) - 255;
  endfunction

  task automatic send_noise();
    send_cmd(func_t'($urandom_range(0, 7)), rand_speed(), rand_speed(), $urandom,
             DIST_W'($urandom), 1'($urandom));
  endtask

  // A drive command (or a random one) followed by a run of ticks, encoder pulses and odd commands
  task automatic drive_sequence();
    int                kind;
    int                events;
    int                pick;
    logic [TIME_W-1:0] dur;
    logic [DIST_W-1:0] ticks;
    no_idle <= ($urandom_range(0, 5) == 0);
    dur   = ($urandom_range(0, 7) == 0) ? $urandom : TIME_W'($urandom_range(1, 12));
    ticks = ($urandom_range(0, 7) == 0) ? DIST_W'($urandom) : DIST_W'($urandom_range(1, 6));
    kind  = $urandom_range(0, 9);
    if (kind <= 3)
      send_cmd(FN_DRIVE_FOR, rand_speed(), rand_speed(), dur, DIST_W'($urandom), 1'($urandom));
    else if (kind <= 6)
      send_cmd(FN_DRIVE_DIST, rand_speed(), rand_speed(), $urandom, ticks, 1'($urandom));
    else if (kind == 7)
      send_cmd(FN_DRIVE, rand_speed(), rand_speed(), $urandom, DIST_W'($urandom), 1'($urandom));
    else if (kind == 8)
      send_cmd(FN_ROTATE, rand_speed(), rand_speed(), $urandom, DIST_W'($urandom),
               ($urandom_range(0, 3) != 0));
    else
      send_noise();
    events = $urandom_range(3, 20);
    repeat (events) begin
      pick = $urandom_range(0, 19);
      if (pick <= 8)
        send_cmd(FN_TICK, rand_speed(), rand_speed(), $urandom, DIST_W'($urandom), 1'($urandom));
      else if (pick <= 12)
        send_cmd(FN_RPULSE, rand_speed(), rand_speed(), $urandom, DIST_W'($urandom),
                 1'($urandom));
      else if (pick <= 16)
        send_cmd(FN_LPULSE, rand_speed(), rand_speed(), $urandom, DIST_W'($urandom),
                 1'($urandom));
      else if (pick == 17)
        send_cmd(FN_STOP, rand_speed(), rand_speed(), $urandom, DIST_W'($urandom), 1'($urandom));
      else
        send_noise();
    end
  endtask

  // Hold the result side off while commands keep coming, so the input stalls
  task automatic stall_burst();
    drain_results();
    hold_reqs <= hold_reqs + 1;
    no_idle   <= 1'b1;
    repeat (12) send_noise();
    no_idle   <= 1'b0;
    drain_results();
  endtask

  initial begin : stimulus
    int directed_count;
    int ph;
    int start_count;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, manual mode at full limit
    program_regs(8'd255, 1'b0);
    send_cmd(FN_DRIVE, 255, 255, '0, '0, 1'b0);        // right saturates, scaled
    send_cmd(FN_DRIVE, -255, -255, '1, '1, 1'b1);
    send_cmd(FN_DRIVE, -255, 255, '0, '0, 1'b0);       // left mixes to -510, scaled
    send_cmd(FN_DRIVE, 0, 0, '0, '0, 1'b0);            // zero command stops
    send_cmd(FN_STOP, 0, 0, '0, '0, 1'b0);             // stop while idle
    send_cmd(FN_ROTATE, 17, -255, '0, '0, 1'b0);       // ignored, angle not positive
    send_cmd(FN_ROTATE, 17, -255, '0, '0, 1'b1);
    send_cmd(FN_DRIVE_DIST, 40, 9, '0, '0, 1'b1);      // zero distance ignored
    send_cmd(FN_DRIVE_DIST, -255, 100, '0, '1, 1'b0);
    send_cmd(FN_DRIVE_FOR, 80, 3, '0, '0, 1'b0);       // zero duration ignored
    send_cmd(FN_DRIVE_FOR, 50, -3, 32'd2, '0, 1'b0);   // armed only once auto mode is on
    send_cmd(FN_TICK, 0, 0, '0, '0, 1'b0);             // manual tick does nothing
    send_cmd(FN_RPULSE, 0, 0, '0, '0, 1'b0);
    send_cmd(FN_LPULSE, 0, 0, '0, '0, 1'b0);
    send_cmd(FN_STOP, 0, 0, '0, '0, 1'b0);             // manual stop keeps timer and state
    send_cmd(FN_DRIVE, 30, 0, '0, '0, 1'b0);
    drain_results();

    // Auto mode, limit of one: the earlier timed drive now ends
    program_regs(8'd1, 1'b1);
    send_cmd(FN_TICK, 0, 0, '0, '0, 1'b0);
    send_cmd(FN_TICK, 0, 0, '0, '0, 1'b0);
    send_cmd(FN_DRIVE_FOR, 200, 77, 32'd3, '0, 1'b0);
    repeat (3) send_cmd(FN_TICK, 0, 0, '0, '0, 1'b0);
    send_cmd(FN_DRIVE_DIST, -10, 0, '0, 24'd1, 1'b0);
    send_cmd(FN_RPULSE, 0, 0, '0, '0, 1'b0);
    send_cmd(FN_TICK, 0, 0, '0, '0, 1'b0);
    send_cmd(FN_LPULSE, 0, 0, '0, '0, 1'b0);
    send_cmd(FN_TICK, 0, 0, '0, '0, 1'b0);
    send_cmd(FN_DRIVE_FOR, 120, -40, 32'd1000, '0, 1'b0);
    drain_results();

    // Manual with zero limit: leaving auto mode drops the timed state
    program_regs(8'd0, 1'b0);
    send_cmd(FN_DRIVE, 5, 5, '0, '0, 1'b0);
    send_cmd(FN_DRIVE, 0, 0, '0, '0, 1'b0);
    drain_results();
    directed_count = sent_count;

    // Random phases over several register settings
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_regs(8'd255, 1'b1);
        1: program_regs(8'd1, 1'b1);
        2: program_regs(LIMIT_W'($urandom_range(1, 255)), 1'b0);
        4: program_regs(8'd255, 1'b0);
        default: program_regs(LIMIT_W'($urandom_range(1, 255)), 1'b1);
      endcase
      start_count = sent_count;
      if (ph == 0)
        stall_burst();
      while (sent_count - start_count < RANDOM_ITEMS / PHASES) begin
        drive_sequence();
        if (ph == 3 && sent_count - start_count > RANDOM_ITEMS / (2 * PHASES) &&
            sent_count - start_count <= RANDOM_ITEMS / (2 * PHASES) + 20)
          drain_results();
      end
      no_idle <= 1'b0;
      drain_results();
    end

    $display("tb: %0d commands sent, %0d of them directed, over %0d register settings",
             sent_count, directed_count, settings_count);
    $display("tb: %0d long output holds; auto stops, pulses and limits exercised",
             long_holds);
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dda_pkg.sv
rtl/core/dda_ctrl.sv
rtl/core/dda_dp.sv
rtl/core/differential_drive_autostop.sv
tb/sv/dda_checker.sv
tb/sv/tb_differential_drive_autostop.sv
